>>> hw/rtl/ipt_pkg.sv
// Shared types, codes and constants for the indexed priority table.
package ipt_pkg;

  localparam int ID_W           = 8;
  localparam int PRIO_W         = 16;
  localparam int CAPACITY_DEF   = 256;
  localparam int STAMP_BITS_DEF = 32;

  localparam logic [PRIO_W-1:0] PRIO_MAX = '1;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_RAISE  = 2'd1,
    FN_REMOVE = 2'd2,
    FN_QUERY  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_REMOVE,
    S_RD,
    S_RAISE,
    S_SCAN,
    S_DRAIN,
    S_PUT
  } state_t;

  typedef struct packed {
    logic load;       // latch the accepted item, reset the scan
    logic insert;
    logic remove;
    logic raise;
    logic scan_step;  // read the next entry and advance the scan index
    logic out_load;   // move the query result into the output register
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

>>> hw/rtl/indexed_priority_table.sv
// Top level of the indexed priority table: controller plus datapath.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-------------------------------------------
//  in      | in  | in_tvalid/in_tready | tuser: func; tdata: entry_id, amount
//  out     | out | out_tvalid/out_tready | tuser: table_empty; tdata: top_entry
//
// Insert and remove each pass through their own state; raise reads, then writes
// back the entry store (S_RD, then S_RAISE). A query scans DEPTH entries,
// DEPTH being min(CAPACITY, 256): the scan reads one entry a cycle from the
// entry store, then passes S_DRAIN and S_PUT. The output register lets the next
// item in while a result waits; a second query result holds until the first is
// taken. Reset clears valid bits and the arrival counter; no clearing pass.
module indexed_priority_table #(
  parameter int CAPACITY   = ipt_pkg::CAPACITY_DEF,
  parameter int STAMP_BITS = ipt_pkg::STAMP_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,    // [1:0] func
  input  logic [23:0] in_tdata,    // [7:0] entry_id, [23:8] amount
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tuser,   // [0] table_empty
  output logic [7:0]  out_tdata    // [7:0] top_entry
);
  import ipt_pkg::*;

  cmd_t    cmd;
  status_t status;

  ipt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_func   (func_t'(in_tuser)),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ipt_datapath #(
    .CAPACITY   (CAPACITY),
    .STAMP_BITS (STAMP_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_id     (in_tdata[7:0]),
    .in_amount (in_tdata[23:8]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_empty (out_tuser),
    .out_top   (out_tdata)
  );

  // a query blocks the input while it scans
  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == FN_QUERY)) |=> !in_tready)
    else $error("input accepted during a query scan");

  // a loaded result is offered on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("query result not presented after load");

  // an empty table reports entry zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 8'd0))
    else $error("empty result carries a nonzero entry id");

endmodule

>>> hw/rtl/ipt_ctrl.sv
// Control state machine of the indexed priority table.
module ipt_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  ipt_pkg::func_t   in_func,
  output logic             in_tready,
  input  ipt_pkg::status_t status,
  output ipt_pkg::cmd_t    cmd
);
  import ipt_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   take;

  assign take = (state_r == S_IDLE) && in_tvalid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          unique case (in_func)
            FN_INSERT: state_nxt = S_INSERT;
            FN_RAISE:  state_nxt = S_RD;
            FN_REMOVE: state_nxt = S_REMOVE;
            FN_QUERY:  state_nxt = S_SCAN;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_INSERT: state_nxt = S_IDLE;
      S_REMOVE: state_nxt = S_IDLE;
      S_RD:     state_nxt = S_RAISE;
      S_RAISE:  state_nxt = S_IDLE;
      S_SCAN: begin
        if (status.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:  state_nxt = S_PUT;
      S_PUT: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = (state_r == S_IDLE);
    cmd.load      = take;
    cmd.insert    = (state_r == S_INSERT);
    cmd.remove    = (state_r == S_REMOVE);
    cmd.raise     = (state_r == S_RAISE);
    cmd.scan_step = (state_r == S_SCAN);
    cmd.out_load  = (state_r == S_PUT) && status.out_free;
  end

endmodule

>>> hw/rtl/ipt_datapath.sv
// Entry stores, valid bits, scan compare and output register of the table.
module ipt_datapath #(
  parameter int CAPACITY   = ipt_pkg::CAPACITY_DEF,
  parameter int STAMP_BITS = ipt_pkg::STAMP_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ipt_pkg::cmd_t             cmd,
  output ipt_pkg::status_t          status,
  input  logic [ipt_pkg::ID_W-1:0]  in_id,
  input  logic [ipt_pkg::PRIO_W-1:0] in_amount,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_empty,
  output logic [ipt_pkg::ID_W-1:0]  out_top
);
  import ipt_pkg::*;

  // ids are ID_W bits wide, so no entry at or beyond 2**ID_W can ever be reached
  localparam int DEPTH = (CAPACITY < (2 ** ID_W)) ? CAPACITY : (2 ** ID_W);
  localparam int IDX_W = $clog2(DEPTH);

  logic [PRIO_W-1:0]     prio_mem  [DEPTH];
  logic [STAMP_BITS-1:0] stamp_mem [DEPTH];

  logic [ID_W-1:0]       op_id_r;
  logic [PRIO_W-1:0]     op_amt_r;
  logic [DEPTH-1:0]      valid_r;
  logic [STAMP_BITS-1:0] arrival_r;
  logic [IDX_W-1:0]      scan_idx_r;
  logic                  cmp_en_r;
  logic [IDX_W-1:0]      cand_id_r;
  logic                  cand_valid_r;
  logic [PRIO_W-1:0]     rd_prio_r;
  logic [STAMP_BITS-1:0] rd_stamp_r;
  logic                  found_r;
  logic [IDX_W-1:0]      best_id_r;
  logic [PRIO_W-1:0]     best_prio_r;
  logic [STAMP_BITS-1:0] best_stamp_r;
  logic                  out_valid_r;
  logic                  out_empty_r;
  logic [ID_W-1:0]       out_top_r;

  logic [IDX_W-1:0]  op_idx;
  logic [IDX_W-1:0]  rd_addr;
  logic              in_range;
  logic              ins_ok;
  logic              raise_ok;
  logic              rem_ok;
  logic [PRIO_W:0]   sum;
  logic [PRIO_W-1:0] sat_sum;
  logic [PRIO_W-1:0] prio_wdata;
  logic              better;

  assign op_idx   = op_id_r[IDX_W-1:0];
  assign in_range = {1'b0, op_id_r} < (ID_W + 1)'(DEPTH);
  assign ins_ok   = cmd.insert && in_range;
  assign rem_ok   = cmd.remove && in_range;
  assign raise_ok = cmd.raise && in_range && valid_r[op_idx];
  assign rd_addr  = cmd.scan_step ? scan_idx_r : op_idx;

  assign sum        = {1'b0, rd_prio_r} + {1'b0, op_amt_r};
  assign sat_sum    = sum[PRIO_W] ? PRIO_MAX : sum[PRIO_W-1:0];
  assign prio_wdata = cmd.insert ? op_amt_r : sat_sum;

  // strict compare: on a full tie the earlier (lower) id stays
  assign better = !found_r || (rd_prio_r > best_prio_r) ||
                  ((rd_prio_r == best_prio_r) && (rd_stamp_r < best_stamp_r));

  always_ff @(posedge clk) begin
    if (ins_ok || raise_ok) begin
      prio_mem[op_idx] <= prio_wdata;
    end
    if (ins_ok) begin
      stamp_mem[op_idx] <= arrival_r;
    end
    rd_prio_r  <= prio_mem[rd_addr];
    rd_stamp_r <= stamp_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_id_r  <= in_id;
      op_amt_r <= in_amount;
    end
    cand_id_r    <= scan_idx_r;
    cand_valid_r <= valid_r[scan_idx_r];
    if (cmp_en_r && cand_valid_r && better) begin
      best_id_r    <= cand_id_r;
      best_prio_r  <= rd_prio_r;
      best_stamp_r <= rd_stamp_r;
    end
    if (cmd.out_load) begin
      out_empty_r <= !found_r;
      out_top_r   <= found_r ? ID_W'(best_id_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      arrival_r   <= '0;
      scan_idx_r  <= '0;
      cmp_en_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ins_ok) begin
        valid_r[op_idx] <= 1'b1;
        arrival_r       <= arrival_r + 1'b1;
      end else if (rem_ok) begin
        valid_r[op_idx] <= 1'b0;
      end
      cmp_en_r <= cmd.scan_step;
      if (cmd.load) begin
        scan_idx_r <= '0;
        found_r    <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          scan_idx_r <= scan_idx_r + 1'b1;
        end
        if (cmp_en_r && cand_valid_r) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.scan_last = (scan_idx_r == IDX_W'(DEPTH - 1));
  assign status.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_empty = out_empty_r;
  assign out_top   = out_top_r;

endmodule
